// ===== src/plt_pkg.sv =====
package plt_pkg;
    localparam int DEPTH    = 32;
    localparam int KEY_BITS = 64;
    localparam int PAY_BITS = 32;
    localparam int POS_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int OP_W     = 3;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic                append;
        logic [POS_W-1:0]    pos;
        logic [KEY_BITS-1:0] key;
        logic [PAY_BITS-1:0] payload;
    } plt_item_t;

    typedef struct packed {
        logic      valid;
        plt_item_t item;
    } plt_head_t;
endpackage

// ===== src/plt_front.sv =====
module plt_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [plt_pkg::OP_W-1:0]   operation,
    input  logic [plt_pkg::POS_W-1:0]  position,
    input  logic                       at_end,
    input  logic [plt_pkg::KEY_BITS-1:0] key,
    input  logic [plt_pkg::PAY_BITS-1:0] payload,
    output plt_pkg::plt_head_t         head,
    input  logic                       take
);
    import plt_pkg::*;

    plt_item_t q_reg [2];
    plt_item_t q_next [2];
    logic [1:0] cnt_reg, cnt_next;
    plt_item_t item;
    logic push, pop;
    logic wr_idx;

    always_comb
    begin
        item.op      = operation;
        item.append  = (operation == OP_INSERT) && at_end;
        item.pos     = position;
        item.key     = key;
        item.payload = payload;
    end

    assign in_stall   = (cnt_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign pop        = take && (cnt_reg != 2'd0);
    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = q_reg[0];
    assign wr_idx     = cnt_reg[0] && !pop;

    always_comb
    begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        // advance the queue before placing the new transaction
        if (pop)
        begin
            q_next[0] = q_reg[1];
        end
        if (push)
        begin
            q_next[wr_idx] = item;
        end
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end
endmodule

// ===== src/plt_back.sv =====
module plt_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  plt_pkg::plt_head_t           head,
    output logic                         take,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         ok,
    output logic                         found,
    output logic [plt_pkg::POS_W-1:0]    found_position,
    output logic [plt_pkg::KEY_BITS-1:0] read_key,
    output logic [plt_pkg::PAY_BITS-1:0] read_payload,
    output logic [plt_pkg::CNT_W-1:0]    count
);
    import plt_pkg::*;

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_FIND = 1'b1;

    logic state_reg, state_next;
    logic [KEY_BITS-1:0] ckey_reg [DEPTH];
    logic [PAY_BITS-1:0] cpay_reg [DEPTH];
    logic [KEY_BITS-1:0] ckey_next [DEPTH];
    logic [PAY_BITS-1:0] cpay_next [DEPTH];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEPTH-1:0] match_reg, match_next;

    logic out_valid_reg, out_valid_next;
    logic ok_reg, ok_next, found_reg, found_next;
    logic [POS_W-1:0] fpos_reg, fpos_next;
    logic [KEY_BITS-1:0] rkey_reg, rkey_next;
    logic [PAY_BITS-1:0] rpay_reg, rpay_next;

    plt_item_t it;
    logic slot_free;
    logic [CNT_W-1:0] pos_ext, ins_pos;
    logic [POS_W-1:0] enc_pos, rd_addr;
    logic ins_ok, idx_ok;

    assign it        = head.item;
    assign slot_free = !out_valid_reg || !out_stall;
    assign take      = (state_reg == ST_RUN) && head.valid && slot_free;
    assign pos_ext   = {{(CNT_W-POS_W){1'b0}}, it.pos};
    assign ins_pos   = it.append ? cnt_reg : pos_ext;
    assign ins_ok    = (cnt_reg < CNT_W'(DEPTH)) && (ins_pos <= cnt_reg);
    assign idx_ok    = pos_ext < cnt_reg;

    // lowest matching cell wins
    always_comb
    begin
        enc_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                enc_pos = POS_W'(i);
            end
        end
    end

    assign rd_addr = (state_reg == ST_FIND) ? enc_pos : it.pos;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        match_next     = match_reg;
        out_valid_next = out_valid_reg && out_stall;
        ok_next        = ok_reg;
        found_next     = found_reg;
        fpos_next      = fpos_reg;
        rkey_next      = rkey_reg;
        rpay_next      = rpay_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            ckey_next[i] = ckey_reg[i];
            cpay_next[i] = cpay_reg[i];
        end

        if (state_reg == ST_FIND)
        begin
            if (slot_free)
            begin
                out_valid_next = 1'b1;
                ok_next        = 1'b1;
                found_next     = |match_reg;
                fpos_next      = enc_pos;
                rkey_next      = (|match_reg) ? ckey_reg[rd_addr] : '0;
                rpay_next      = (|match_reg) ? cpay_reg[rd_addr] : '0;
                state_next     = ST_RUN;
            end
        end
        else if (take)
        begin
            ok_next    = 1'b0;
            found_next = 1'b0;
            fpos_next  = '0;
            rkey_next  = '0;
            rpay_next  = '0;
            out_valid_next = 1'b1;
            case (it.op)
                OP_CLEAR:
                begin
                    cnt_next = '0;
                    ok_next  = 1'b1;
                end
                OP_INSERT:
                begin
                    if (ins_ok)
                    begin
                        // shift cells at and above the slot one place up
                        for (int i = 1; i < DEPTH; i++)
                        begin
                            if (CNT_W'(i) > ins_pos)
                            begin
                                ckey_next[i] = ckey_reg[i-1];
                                cpay_next[i] = cpay_reg[i-1];
                            end
                        end
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (CNT_W'(i) == ins_pos)
                            begin
                                ckey_next[i] = it.key;
                                cpay_next[i] = it.payload;
                            end
                        end
                        cnt_next = cnt_reg + CNT_W'(1);
                        ok_next  = 1'b1;
                    end
                end
                OP_DELETE:
                begin
                    if (idx_ok)
                    begin
                        for (int i = 0; i < DEPTH - 1; i++)
                        begin
                            if (CNT_W'(i) >= pos_ext)
                            begin
                                ckey_next[i] = ckey_reg[i+1];
                                cpay_next[i] = cpay_reg[i+1];
                            end
                        end
                        cnt_next = cnt_reg - CNT_W'(1);
                        ok_next  = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (idx_ok)
                    begin
                        rkey_next = ckey_reg[rd_addr];
                        rpay_next = cpay_reg[rd_addr];
                        ok_next   = 1'b1;
                    end
                end
                OP_UPDATE:
                begin
                    if (idx_ok)
                    begin
                        ckey_next[it.pos] = it.key;
                        cpay_next[it.pos] = it.payload;
                        ok_next           = 1'b1;
                    end
                end
                OP_FIND:
                begin
                    // hold the result back: register the match vector, then pick the first match in ST_FIND
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        match_next[i] = (CNT_W'(i) < cnt_reg) && (ckey_reg[i] == it.key);
                    end
                    out_valid_next = out_valid_reg && out_stall;
                    state_next     = ST_FIND;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ckey_reg[i] <= ckey_next[i];
            cpay_reg[i] <= cpay_next[i];
        end
        match_reg <= match_next;
        ok_reg    <= ok_next;
        found_reg <= found_next;
        fpos_reg  <= fpos_next;
        rkey_reg  <= rkey_next;
        rpay_reg  <= rpay_next;
    end

    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign found          = found_reg;
    assign found_position = fpos_reg;
    assign read_key       = rkey_reg;
    assign read_payload   = rpay_reg;
    assign count          = cnt_reg;
endmodule

// ===== src/positional_list_table.sv =====
// A transaction passes the two-entry queue; the output register is loaded when the cell
// array takes it, a find after its match vector is registered and the first match picked.
// Throughput: one transaction per cycle when not stalled and no find is pending.
// A two-entry queue parts input and cell array; the output register parts the rest.
// Reset (rst_n low, asynchronous): queue empty, count 0, no result pending.
// Cell contents are not reset; only cells below the count are ever read.
module positional_list_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [plt_pkg::OP_W-1:0]     operation,
    input  logic [plt_pkg::POS_W-1:0]    position,
    input  logic                         at_end,
    input  logic [plt_pkg::KEY_BITS-1:0] key,
    input  logic [plt_pkg::PAY_BITS-1:0] payload,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         ok,
    output logic                         found,
    output logic [plt_pkg::POS_W-1:0]    found_position,
    output logic [plt_pkg::KEY_BITS-1:0] read_key,
    output logic [plt_pkg::PAY_BITS-1:0] read_payload,
    output logic [plt_pkg::CNT_W-1:0]    count
);
    import plt_pkg::*;

    plt_head_t head;
    logic take;

    plt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .position  (position),
        .at_end    (at_end),
        .key       (key),
        .payload   (payload),
        .head      (head),
        .take      (take)
    );

    plt_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .take           (take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .found          (found),
        .found_position (found_position),
        .read_key       (read_key),
        .read_payload   (read_payload),
        .count          (count)
    );
endmodule

// ===== src/plt_checker.sv =====
module plt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         ok,
    input logic                         found,
    input logic [plt_pkg::POS_W-1:0]    found_position,
    input logic [plt_pkg::KEY_BITS-1:0] read_key,
    input logic [plt_pkg::CNT_W-1:0]    count
);
    import plt_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(count) && $stable(read_key) && $stable(ok))
        else $error("stalled result changed");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> ok)
        else $error("found without ok");

    a_nofind_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> found_position == '0)
        else $error("position given without a match");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count <= CNT_W'(DEPTH))
        else $error("count beyond depth");
endmodule

bind positional_list_table plt_checker u_plt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ok             (ok),
    .found          (found),
    .found_position (found_position),
    .read_key       (read_key),
    .count          (count)
);

// ===== tb/sv/tb_positional_list_table.sv =====
module tb_positional_list_table;
    timeunit 1ns;
    timeprecision 1ps;
    import plt_pkg::*;

    typedef struct {
        logic                ok;
        logic                found;
        logic [POS_W-1:0]    fpos;
        logic [KEY_BITS-1:0] rkey;
        logic [PAY_BITS-1:0] rpay;
        logic [CNT_W-1:0]    cnt;
    } list_result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [OP_W-1:0]     operation;
    logic [POS_W-1:0]    position;
    logic                at_end;
    logic [KEY_BITS-1:0] key;
    logic [PAY_BITS-1:0] payload;
    logic                out_valid;
    logic                out_stall;
    logic                ok;
    logic                found;
    logic [POS_W-1:0]    found_position;
    logic [KEY_BITS-1:0] read_key;
    logic [PAY_BITS-1:0] read_payload;
    logic [CNT_W-1:0]    count;

    positional_list_table u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .position       (position),
        .at_end         (at_end),
        .key            (key),
        .payload        (payload),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .found          (found),
        .found_position (found_position),
        .read_key       (read_key),
        .read_payload   (read_payload),
        .count          (count)
    );

    plt_item_t           pending_ops[$];
    list_result_t        expected_results[$];
    logic [KEY_BITS-1:0] list_keys[DEPTH];
    logic [PAY_BITS-1:0] list_pays[DEPTH];
    int                  list_len;
    int                  errors;
    int                  burst_left;
    int                  gap_left;
    int                  hold_off;
    int                  stall_phase;
    logic [KEY_BITS-1:0] key_pool[8];

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic list_result_t apply_list_op(plt_item_t it);
        list_result_t r;
        int p;
        r = '{default: '0};
        p = it.pos;
        case (it.op)
            OP_CLEAR:
            begin
                list_len = 0;
                r.ok = 1'b1;
            end
            OP_INSERT:
            begin
                if (it.append)
                    p = list_len;
                if (list_len < DEPTH && p <= list_len)
                begin
                    for (int i = list_len; i > p; i--)
                    begin
                        list_keys[i] = list_keys[i-1];
                        list_pays[i] = list_pays[i-1];
                    end
                    list_keys[p] = it.key;
                    list_pays[p] = it.payload;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (p < list_len)
                begin
                    for (int i = p; i + 1 < list_len; i++)
                    begin
                        list_keys[i] = list_keys[i+1];
                        list_pays[i] = list_pays[i+1];
                    end
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            OP_READ:
            begin
                if (p < list_len)
                begin
                    r.rkey = list_keys[p];
                    r.rpay = list_pays[p];
                    r.ok   = 1'b1;
                end
            end
            OP_UPDATE:
            begin
                if (p < list_len)
                begin
                    list_keys[p] = it.key;
                    list_pays[p] = it.payload;
                    r.ok = 1'b1;
                end
            end
            OP_FIND:
            begin
                r.ok = 1'b1;
                for (int i = 0; i < list_len; i++)
                begin
                    if (list_keys[i] == it.key)
                    begin
                        r.found = 1'b1;
                        r.fpos  = POS_W'(i);
                        r.rkey  = list_keys[i];
                        r.rpay  = list_pays[i];
                        break;
                    end
                end
            end
            default:
                r.ok = 1'b0;
        endcase
        r.cnt = CNT_W'(list_len);
        return r;
    endfunction

    function automatic plt_item_t make_op(logic [OP_W-1:0] op, int pos, logic app,
                                          logic [KEY_BITS-1:0] k, logic [PAY_BITS-1:0] d);
        plt_item_t it;
        it.op      = op;
        it.pos     = POS_W'(pos);
        it.append  = app;
        it.key     = k;
        it.payload = d;
        return it;
    endfunction

    function automatic logic [KEY_BITS-1:0] rand_key();
        if ($urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, 7)];
        return {$urandom, $urandom};
    endfunction

    // Driver: bursts with random gaps, payload held while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_ops.size() > 0)
            begin
                plt_item_t it;
                it = pending_ops.pop_front();
                in_valid  <= 1'b1;
                operation <= it.op;
                position  <= it.pos;
                at_end    <= it.append;
                key       <= it.key;
                payload   <= it.payload;
                if (burst_left <= 0)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Predict at acceptance; the queue in front of the cells preserves order.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            expected_results.push_back(apply_list_op(make_op(operation, position, at_end,
                                                             key, payload)));
    end

    // Receiver stall pattern, with one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (hold_off > 0)
                out_stall <= 1'b1;
            else if (stall_phase[9:8] == 2'd0)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected transaction ok=%0b count=%0d", $realtime, ok, count);
                errors++;
            end
            else
            begin
                list_result_t e;
                e = expected_results.pop_front();
                if (ok !== e.ok)
                begin
                    $display("%0t: ok expected %0b actual %0b", $realtime, e.ok, ok);
                    errors++;
                end
                if (found !== e.found)
                begin
                    $display("%0t: found expected %0b actual %0b", $realtime, e.found, found);
                    errors++;
                end
                if (found_position !== e.fpos)
                begin
                    $display("%0t: found_position expected %0d actual %0d",
                             $realtime, e.fpos, found_position);
                    errors++;
                end
                if (read_key !== e.rkey)
                begin
                    $display("%0t: read_key expected %h actual %h", $realtime, e.rkey, read_key);
                    errors++;
                end
                if (read_payload !== e.rpay)
                begin
                    $display("%0t: read_payload expected %h actual %h",
                             $realtime, e.rpay, read_payload);
                    errors++;
                end
                if (count !== e.cnt)
                begin
                    $display("%0t: count expected %0d actual %0d", $realtime, e.cnt, count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("FAIL positional_list_table");
        $finish;
    end

    initial
    begin
        int len;
        int r;
        errors    = 0;
        list_len  = 0;
        hold_off  = 0;
        in_valid  = 1'b0;
        out_stall = 1'b0;
        operation = OP_CLEAR;
        position  = '0;
        at_end    = 1'b0;
        key       = '0;
        payload   = '0;
        rst_n     = 1'b0;
        for (int i = 0; i < 8; i++)
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;

        // Directed: empty-list refusals, extremes, fill to full, unknown codes.
        pending_ops.push_back(make_op(OP_READ, 0, 0, '0, '0));
        pending_ops.push_back(make_op(OP_DELETE, 0, 0, '0, '0));
        pending_ops.push_back(make_op(OP_UPDATE, 0, 0, '1, '1));
        pending_ops.push_back(make_op(OP_FIND, 0, 0, '0, '0));
        pending_ops.push_back(make_op(OP_INSERT, 1, 0, '1, '1));
        pending_ops.push_back(make_op(OP_INSERT, 31, 1, '1, '1));
        pending_ops.push_back(make_op(OP_INSERT, 0, 0, '0, '0));
        pending_ops.push_back(make_op(OP_INSERT, 1, 0, 64'h4e49434b4e414d45, 32'h5a5a5a5a));
        pending_ops.push_back(make_op(OP_FIND, 0, 0, '1, '0));
        pending_ops.push_back(make_op(OP_FIND, 0, 0, 64'h4e49434b4e414d45, '0));
        pending_ops.push_back(make_op(OP_READ, 2, 0, '0, '0));
        pending_ops.push_back(make_op(OP_READ, 31, 0, '0, '0));
        pending_ops.push_back(make_op(OP_UPDATE, 1, 0, 64'h0123456789abcdef, 32'h80000001));
        pending_ops.push_back(make_op(3'd6, 0, 0, '0, '0));
        pending_ops.push_back(make_op(3'd7, 31, 1, '1, '1));
        for (int i = 0; i < DEPTH; i++)
            pending_ops.push_back(make_op(OP_INSERT, $urandom_range(0, 2), 1,
                                          {$urandom, $urandom}, $urandom));
        pending_ops.push_back(make_op(OP_READ, 31, 0, '0, '0));
        pending_ops.push_back(make_op(OP_DELETE, 31, 0, '0, '0));
        pending_ops.push_back(make_op(OP_DELETE, 0, 0, '0, '0));
        pending_ops.push_back(make_op(OP_CLEAR, 0, 0, '0, '0));

        // Random: track the length to keep positions mostly in range.
        len = 0;
        for (int n = 0; n < 600; n++)
        begin
            plt_item_t it;
            r = $urandom_range(0, 99);
            it = make_op(OP_FIND, 0, 0, rand_key(), $urandom);
            if (r < 2)
                it.op = OP_W'(6 + $urandom_range(0, 1));
            else if (r < 4)
                it.op = OP_CLEAR;
            else if (r < 40)
                it.op = OP_INSERT;
            else if (r < 58)
                it.op = OP_DELETE;
            else if (r < 74)
                it.op = OP_READ;
            else if (r < 86)
                it.op = OP_UPDATE;
            it.append = (it.op == OP_INSERT) ? ($urandom_range(0, 2) == 0)
                                             : 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0 || len == 0)
                it.pos = POS_W'($urandom_range(0, 31));
            else
                it.pos = POS_W'($urandom_range(0, (it.op == OP_INSERT) ? len : len - 1));
            if (it.op == OP_CLEAR)
                len = 0;
            else if (it.op == OP_INSERT && len < DEPTH && (it.append || it.pos <= len))
                len++;
            else if (it.op == OP_DELETE && it.pos < len)
                len--;
            pending_ops.push_back(it);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_ops.size() < 400);
        @(posedge clk);
        hold_off <= 200;

        wait (pending_ops.size() == 0);
        while (expected_results.size() > 0 || in_valid)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("PASS positional_list_table");
        else
            $display("FAIL positional_list_table");
        $finish;
    end
endmodule
